// File: hdl/wsfe_pkg.sv
// ----------------------------------------------------------------------------
// wsfe_pkg
// Shared types, constants and twiddle functions of the STFT frame engine.
// ----------------------------------------------------------------------------
package wsfe_pkg;

    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = 6;
    localparam int SAMP_W     = 17;
    localparam int COEF_W     = 16;
    localparam int PART_W     = 23;
    localparam int TW_W       = 17;
    localparam int TWK_W      = 5;
    localparam int PROD_W     = 40;
    localparam int ACC_W      = 41;
    localparam int WLEN_W     = 7;
    localparam int HOP_W      = 13;
    localparam int FRAME_W    = 16;
    localparam int BIN_W      = 6;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 72;

    localparam logic [COEF_W-1:0] COEF_ONE    = 16'h8000;
    localparam logic [WLEN_W-1:0] WLEN_MAX    = 7'd64;
    localparam logic [HOP_W-1:0]  WLEN_RESET  = 13'd64;
    localparam logic [HOP_W-1:0]  HOP_RESET   = 13'd32;

    localparam logic CFG_WINDOW_LENGTH = 1'b0;
    localparam logic CFG_HOP_LENGTH    = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD_COEF = 2'd0,
        ACT_PUSH      = 2'd1,
        ACT_RESTART   = 2'd2,
        ACT_NOP       = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_LD_RD, ST_LD_MUL, ST_LD_WR,
        ST_BF_RD, ST_BF_M0, ST_BF_M1, ST_BF_M2, ST_BF_M3, ST_BF_M4,
        ST_BF_WA, ST_BF_WB, ST_EM_RD, ST_EM_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_WIN, MUL_BR_C, MUL_BI_S, MUL_BI_C, MUL_BR_S
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD, ACC_RE_SET, ACC_RE_ADD, ACC_IM_SET, ACC_IM_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        WR_LOAD, WR_SUM, WR_DIFF
    } wr_sel_t;

    typedef struct packed {
        logic     ring_wr;
        logic     win_wr;
        logic     src_rd;
        logic     work_rd;
        logic     work_wr;
        wr_sel_t  wr_sel;
        logic     load_zero;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     out_load;
        logic     out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    // round(32768 * cos(pi * k / 32)) for k = 0..16
    function automatic logic signed [TW_W-1:0] quarter_cos(input logic [TWK_W-1:0] k);
        logic signed [TW_W-1:0] v;
        begin
            case (k)
                5'd0:  v = 17'sd32768;
                5'd1:  v = 17'sd32610;
                5'd2:  v = 17'sd32138;
                5'd3:  v = 17'sd31357;
                5'd4:  v = 17'sd30274;
                5'd5:  v = 17'sd28899;
                5'd6:  v = 17'sd27246;
                5'd7:  v = 17'sd25330;
                5'd8:  v = 17'sd23170;
                5'd9:  v = 17'sd20788;
                5'd10: v = 17'sd18205;
                5'd11: v = 17'sd15447;
                5'd12: v = 17'sd12540;
                5'd13: v = 17'sd9512;
                5'd14: v = 17'sd6393;
                5'd15: v = 17'sd3212;
                default: v = 17'sd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [TW_W-1:0] tw_cos(input logic [TWK_W-1:0] k);
        logic [TWK_W:0] rk;
        begin
            rk = 6'd32 - {1'b0, k};
            if (k <= 5'd16) begin
                return quarter_cos(k);
            end
            return -quarter_cos(rk[TWK_W-1:0]);
        end
    endfunction

    function automatic logic signed [TW_W-1:0] tw_sin(input logic [TWK_W-1:0] k);
        begin
            if (k <= 5'd16) begin
                return quarter_cos(5'd16 - k);
            end
            return quarter_cos(k - 5'd16);
        end
    endfunction

endpackage

// File: hdl/wsfe_dp.sv
// ----------------------------------------------------------------------------
// wsfe_dp
// Datapath: sample ring, window table, FFT work store, shared multiplier,
// butterfly accumulators and the result register.
// ----------------------------------------------------------------------------
module wsfe_dp #(
    parameter int FFT_SIZE    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  wsfe_pkg::dp_cmd_t                 cmd,
    output wsfe_pkg::dp_stat_t                stat,
    input  logic [15:0]                       in_sample,
    input  logic [5:0]                        in_coef_index,
    input  logic [15:0]                       in_coef_value,
    input  logic [5:0]                        ring_wr_addr,
    input  logic [5:0]                        ring_rd_addr,
    input  logic [5:0]                        win_rd_addr,
    input  logic [$clog2(FFT_SIZE)-1:0]       work_a_addr,
    input  logic [$clog2(FFT_SIZE)-1:0]       work_b_addr,
    input  logic [$clog2(FFT_SIZE)-1:0]       work_wr_addr,
    input  logic [4:0]                        tw_k,
    input  logic [5:0]                        out_bin,
    input  logic [15:0]                       out_frame,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [5:0]                        m_bin,
    output logic [15:0]                       m_frame,
    output logic signed [22:0]                m_real,
    output logic signed [22:0]                m_imag,
    output logic                              m_last
);
    import wsfe_pkg::*;

    localparam int SB    = (SAMPLE_BITS > 16) ? 16 : SAMPLE_BITS;
    localparam bit SX    = (SAMPLE_BITS <= 16);

    logic signed [SAMP_W-1:0] ring_mem [RING_DEPTH];
    logic [COEF_W-1:0]        win_mem  [RING_DEPTH];
    logic signed [PART_W-1:0] work_re  [FFT_SIZE];
    logic signed [PART_W-1:0] work_im  [FFT_SIZE];

    logic signed [SAMP_W-1:0] ring_q_reg;
    logic [COEF_W-1:0]        win_q_reg;
    logic signed [PART_W-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_re_reg, acc_im_reg;
    logic                     m_valid_reg;

    logic [SAMP_W-1:0]        samp17;
    logic signed [SAMP_W-1:0] samp_ext;
    logic [COEF_W-1:0]        coef_clamped;
    logic signed [PART_W-1:0] mul_a;
    logic signed [TW_W-1:0]   mul_b;
    logic signed [TW_W-1:0]   tw_c, tw_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  ld_sum, ld_rnd;
    logic signed [ACC_W:0]    tr_sum, ti_sum, tr_rnd, ti_rnd;
    logic signed [PART_W-1:0] tr, ti, wr_re, wr_im;

    // Sign extension from SAMPLE_BITS; wider settings take the port as unsigned.
    always_comb begin
        samp17 = {1'b0, in_sample};
        for (int b = 0; b < SAMP_W; b++) begin
            if (b < SB) begin
                samp_ext[b] = samp17[b];
            end else begin
                samp_ext[b] = SX ? samp17[SB-1] : 1'b0;
            end
        end
    end

    assign coef_clamped = (in_coef_value > COEF_ONE) ? COEF_ONE : in_coef_value;
    assign tw_c = tw_cos(tw_k);
    assign tw_s = tw_sin(tw_k);

    always_comb begin
        case (cmd.mul_sel)
            MUL_BR_C: begin mul_a = br_reg; mul_b = tw_c; end
            MUL_BI_S: begin mul_a = bi_reg; mul_b = tw_s; end
            MUL_BI_C: begin mul_a = bi_reg; mul_b = tw_c; end
            MUL_BR_S: begin mul_a = br_reg; mul_b = tw_s; end
            default: begin
                mul_a = PART_W'(ring_q_reg);
                mul_b = signed'({1'b0, win_q_reg});
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Q15 rounding is a floor after adding one half, so an arithmetic shift.
    assign ld_sum = ACC_W'(prod_reg) + 41'sd16384;
    assign ld_rnd = ld_sum >>> 15;
    assign tr_sum = (ACC_W+1)'(acc_re_reg) + 42'sd16384;
    assign ti_sum = (ACC_W+1)'(acc_im_reg) + 42'sd16384;
    assign tr_rnd = tr_sum >>> 15;
    assign ti_rnd = ti_sum >>> 15;
    assign tr     = tr_rnd[PART_W-1:0];
    assign ti     = ti_rnd[PART_W-1:0];

    always_comb begin
        case (cmd.wr_sel)
            WR_SUM: begin wr_re = ar_reg + tr; wr_im = ai_reg + ti; end
            WR_DIFF: begin wr_re = ar_reg - tr; wr_im = ai_reg - ti; end
            default: begin
                wr_re = cmd.load_zero ? '0 : ld_rnd[PART_W-1:0];
                wr_im = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.ring_wr) begin
            ring_mem[ring_wr_addr] <= samp_ext;
        end
        if (cmd.win_wr) begin
            win_mem[in_coef_index] <= coef_clamped;
        end
        if (cmd.src_rd) begin
            ring_q_reg <= ring_mem[ring_rd_addr];
            win_q_reg  <= win_mem[win_rd_addr];
        end
        if (cmd.work_rd) begin
            ar_reg <= work_re[work_a_addr];
            ai_reg <= work_im[work_a_addr];
            br_reg <= work_re[work_b_addr];
            bi_reg <= work_im[work_b_addr];
        end
        if (cmd.work_wr) begin
            work_re[work_wr_addr] <= wr_re;
            work_im[work_wr_addr] <= wr_im;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod;
        case (cmd.acc_op)
            ACC_RE_SET: acc_re_reg <= ACC_W'(prod_reg);
            ACC_RE_ADD: acc_re_reg <= acc_re_reg + ACC_W'(prod_reg);
            ACC_IM_SET: acc_im_reg <= ACC_W'(prod_reg);
            ACC_IM_SUB: acc_im_reg <= acc_im_reg - ACC_W'(prod_reg);
            default: ;
        endcase
        if (cmd.out_load) begin
            m_bin   <= out_bin;
            m_frame <= out_frame;
            m_real  <= ar_reg;
            m_imag  <= ai_reg;
            m_last  <= cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

endmodule

// File: hdl/wsfe_ctrl.sv
// ----------------------------------------------------------------------------
// wsfe_ctrl
// Controller: stream counters, configuration registers and the sequencer
// that runs the window load, the butterfly passes and the bin emission.
// ----------------------------------------------------------------------------
module wsfe_ctrl #(
    parameter int FFT_SIZE = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_action,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [12:0]                  cfg_data,
    input  wsfe_pkg::dp_stat_t           stat,
    output wsfe_pkg::dp_cmd_t            cmd,
    output logic [5:0]                   ring_wr_addr,
    output logic [5:0]                   ring_rd_addr,
    output logic [5:0]                   win_rd_addr,
    output logic [$clog2(FFT_SIZE)-1:0]  work_a_addr,
    output logic [$clog2(FFT_SIZE)-1:0]  work_b_addr,
    output logic [$clog2(FFT_SIZE)-1:0]  work_wr_addr,
    output logic [4:0]                   tw_k,
    output logic [5:0]                   out_bin,
    output logic [15:0]                  out_frame
);
    import wsfe_pkg::*;

    localparam int LOG_N = $clog2(FFT_SIZE);
    localparam int SW    = $clog2(LOG_N);
    localparam logic [LOG_N-1:0] PT_LAST  = LOG_N'(FFT_SIZE - 1);
    localparam logic [LOG_N-1:0] BIN_LAST = LOG_N'(FFT_SIZE / 2);
    localparam logic [LOG_N-2:0] BF_LAST  = (LOG_N-1)'(FFT_SIZE / 2 - 1);
    localparam logic [SW-1:0]    STG_LAST = SW'(LOG_N - 1);

    state_t              state_reg, state_next;
    logic [WLEN_W-1:0]   wl_reg, wl_next;
    logic [HOP_W-1:0]    hop_reg, hop_next;
    logic [RING_AW-1:0]  wp_reg, wp_next;
    logic [HOP_W-1:0]    suf_reg, suf_next;
    logic [FRAME_W-1:0]  fc_reg, fc_next;
    logic [LOG_N-1:0]    pt_reg, pt_next;
    logic [SW-1:0]       stg_reg, stg_next;
    logic [LOG_N-2:0]    bf_reg, bf_next;

    logic                in_fire, cfg_fire;
    logic [WLEN_W-1:0]   len, cfg_len;
    logic [HOP_W-1:0]    hop_eff;
    logic [WLEN_W-1:0]   pos_full;
    logic [LOG_N-1:0]    bf_ext, hmask, j, addr_a, addr_b, rev_pt;
    logic [5:0]          k_full;

    function automatic logic [WLEN_W-1:0] clamp_len(input logic [WLEN_W-1:0] w);
        begin
            if (w == '0) begin
                return WLEN_W'(1);
            end
            return (w > WLEN_MAX) ? WLEN_MAX : w;
        end
    endfunction

    assign len      = clamp_len(wl_reg);
    assign cfg_len  = clamp_len(cfg_data[WLEN_W-1:0]);
    assign hop_eff  = (hop_reg == '0) ? HOP_W'(1) : hop_reg;
    assign in_ready = (state_reg == ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign cfg_fire = cfg_valid && cfg_ready;

    // Frame point i reads the ring len samples back from the write pointer.
    assign pos_full     = {1'b0, wp_reg} - len + WLEN_W'(pt_reg);
    assign ring_rd_addr = pos_full[RING_AW-1:0];
    assign ring_wr_addr = wp_reg;
    assign win_rd_addr  = RING_AW'(pt_reg);

    always_comb begin
        for (int b = 0; b < LOG_N; b++) begin
            rev_pt[b] = pt_reg[LOG_N-1-b];
        end
    end

    // Butterfly n of stage s: a = group*2h + j, b = a + h, twiddle j * 64/(2h).
    assign bf_ext = {1'b0, bf_reg};
    assign hmask  = LOG_N'((1 << stg_reg) - 1);
    assign j      = bf_ext & hmask;
    assign addr_a = ((bf_ext & ~hmask) << 1) | j;
    assign addr_b = addr_a | LOG_N'(1 << stg_reg);
    assign k_full = 6'(j) << (3'd5 - 3'(stg_reg));
    assign tw_k   = k_full[4:0];

    assign work_a_addr  = (state_reg == ST_EM_RD) ? pt_reg : addr_a;
    assign work_b_addr  = addr_b;
    assign work_wr_addr = (state_reg == ST_LD_WR) ? rev_pt :
                          (state_reg == ST_BF_WB) ? addr_b : addr_a;
    assign out_bin      = BIN_W'(pt_reg);
    assign out_frame    = fc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            wl_reg    <= WLEN_MAX;
            hop_reg   <= HOP_RESET;
            wp_reg    <= '0;
            suf_reg   <= WLEN_RESET;
            fc_reg    <= '0;
            pt_reg    <= '0;
            stg_reg   <= '0;
            bf_reg    <= '0;
        end else begin
            state_reg <= state_next;
            wl_reg    <= wl_next;
            hop_reg   <= hop_next;
            wp_reg    <= wp_next;
            suf_reg   <= suf_next;
            fc_reg    <= fc_next;
            pt_reg    <= pt_next;
            stg_reg   <= stg_next;
            bf_reg    <= bf_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        wl_next    = wl_reg;
        hop_next   = hop_reg;
        wp_next    = wp_reg;
        suf_next   = suf_reg;
        fc_next    = fc_reg;
        pt_next    = pt_reg;
        stg_next   = stg_reg;
        bf_next    = bf_reg;
        cmd        = '0;
        cmd.wr_sel = WR_LOAD;
        cmd.mul_sel = MUL_WIN;
        cmd.acc_op = ACC_HOLD;

        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_fire) begin
                    if (cfg_index == CFG_WINDOW_LENGTH) begin
                        wl_next  = cfg_data[WLEN_W-1:0];
                        wp_next  = '0;
                        suf_next = HOP_W'(cfg_len);
                        fc_next  = '0;
                    end else begin
                        hop_next = cfg_data;
                    end
                end
                if (in_fire) begin
                    case (in_action)
                        ACT_LOAD_COEF: cmd.win_wr = 1'b1;
                        ACT_RESTART: begin
                            wp_next  = '0;
                            suf_next = HOP_W'(len);
                            fc_next  = '0;
                        end
                        ACT_PUSH: begin
                            cmd.ring_wr = 1'b1;
                            wp_next     = wp_reg + 1'b1;
                            if (suf_reg <= HOP_W'(1)) begin
                                suf_next   = hop_eff;
                                pt_next    = '0;
                                state_next = ST_LD_RD;
                            end else begin
                                suf_next = suf_reg - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_LD_RD: begin
                cmd.src_rd = 1'b1;
                state_next = ST_LD_MUL;
            end
            ST_LD_MUL: begin
                cmd.mul_sel = MUL_WIN;
                state_next  = ST_LD_WR;
            end
            ST_LD_WR: begin
                cmd.work_wr   = 1'b1;
                cmd.wr_sel    = WR_LOAD;
                cmd.load_zero = (WLEN_W'(pt_reg) >= len);
                if (pt_reg == PT_LAST) begin
                    stg_next   = '0;
                    bf_next    = '0;
                    state_next = ST_BF_RD;
                end else begin
                    pt_next    = pt_reg + 1'b1;
                    state_next = ST_LD_RD;
                end
            end
            ST_BF_RD: begin
                cmd.work_rd = 1'b1;
                state_next  = ST_BF_M0;
            end
            ST_BF_M0: begin
                cmd.mul_sel = MUL_BR_C;
                state_next  = ST_BF_M1;
            end
            ST_BF_M1: begin
                cmd.mul_sel = MUL_BI_S;
                cmd.acc_op  = ACC_RE_SET;
                state_next  = ST_BF_M2;
            end
            ST_BF_M2: begin
                cmd.mul_sel = MUL_BI_C;
                cmd.acc_op  = ACC_RE_ADD;
                state_next  = ST_BF_M3;
            end
            ST_BF_M3: begin
                cmd.mul_sel = MUL_BR_S;
                cmd.acc_op  = ACC_IM_SET;
                state_next  = ST_BF_M4;
            end
            ST_BF_M4: begin
                cmd.acc_op = ACC_IM_SUB;
                state_next = ST_BF_WA;
            end
            ST_BF_WA: begin
                cmd.work_wr = 1'b1;
                cmd.wr_sel  = WR_SUM;
                state_next  = ST_BF_WB;
            end
            ST_BF_WB: begin
                cmd.work_wr = 1'b1;
                cmd.wr_sel  = WR_DIFF;
                if (bf_reg == BF_LAST) begin
                    bf_next = '0;
                    if (stg_reg == STG_LAST) begin
                        pt_next    = '0;
                        state_next = ST_EM_RD;
                    end else begin
                        stg_next   = stg_reg + 1'b1;
                        state_next = ST_BF_RD;
                    end
                end else begin
                    bf_next    = bf_reg + 1'b1;
                    state_next = ST_BF_RD;
                end
            end
            ST_EM_RD: begin
                cmd.work_rd = 1'b1;
                state_next  = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = (pt_reg == BIN_LAST);
                    if (pt_reg == BIN_LAST) begin
                        fc_next    = fc_reg + 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        pt_next    = pt_reg + 1'b1;
                        state_next = ST_EM_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_no_write_on_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !cmd.work_wr && stat.out_free)
        else $error("result loaded while work store written or output busy");

    a_frame_start: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_action == ACT_PUSH && suf_reg <= HOP_W'(1) |=> state_reg == ST_LD_RD)
        else $error("frame did not start after countdown expired");

    a_bfly_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_BF_WA |=> state_reg == ST_BF_WB)
        else $error("butterfly lower write skipped");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load && cmd.out_last |=> state_reg == ST_IDLE && fc_reg == $past(fc_reg) + 1'b1)
        else $error("frame end did not return to idle");

endmodule

// File: hdl/windowed_stft_frame_engine_unit.sv
// ----------------------------------------------------------------------------
// windowed_stft_frame_engine_unit
// Windowed short-time Fourier transform frame engine, top level.
// ----------------------------------------------------------------------------
// Usage: load the Q1.15 window through load beats on the slave stream, then
// push samples. When a frame completes (after window_length samples, then every
// hop_length samples) the block forms the windowed, zero-padded frame, runs an
// in-place radix-2 FFT on one shared multiplier and emits bins 0..FFT_SIZE/2 on
// the master stream, tlast on the final bin. The slave stream and the
// configuration port are not ready while a frame is in work.
// Frame work: each point is loaded with a ring and window read, a multiply and
// a write; each butterfly takes a read, four multiplies through the single
// multiplier and two writes; each bin emitted takes a read and an output load.
// A stalled master side holds the current bin and freezes the sequencer.
// Reset (aresetn low, synchronous) clears the counters and the registers to
// window_length 64, hop_length 32; the sample ring, window table and work
// store are not cleared and hold nothing meaningful until written.
// ----------------------------------------------------------------------------
module windowed_stft_frame_engine_unit #(
    parameter int FFT_SIZE    = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // coef_index[5:0], coef_value[21:6], sample[37:22]
    input  logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // bin_index[5:0], frame_index[21:6],
                                        // real_part[44:22], imag_part[67:45]
    output logic        m_axis_tlast,   // last_bin
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);
    import wsfe_pkg::*;

    localparam int LOG_N = $clog2(FFT_SIZE);

    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic [5:0]           ring_wr_addr, ring_rd_addr, win_rd_addr;
    logic [LOG_N-1:0]     work_a_addr, work_b_addr, work_wr_addr;
    logic [4:0]           tw_k;
    logic [5:0]           out_bin, m_bin;
    logic [15:0]          out_frame, m_frame;
    logic signed [22:0]   m_real, m_imag;

    wsfe_ctrl #(.FFT_SIZE(FFT_SIZE)) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_action    (s_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .stat         (stat),
        .cmd          (cmd),
        .ring_wr_addr (ring_wr_addr),
        .ring_rd_addr (ring_rd_addr),
        .win_rd_addr  (win_rd_addr),
        .work_a_addr  (work_a_addr),
        .work_b_addr  (work_b_addr),
        .work_wr_addr (work_wr_addr),
        .tw_k         (tw_k),
        .out_bin      (out_bin),
        .out_frame    (out_frame)
    );

    wsfe_dp #(.FFT_SIZE(FFT_SIZE), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .in_sample     (s_axis_tdata[37:22]),
        .in_coef_index (s_axis_tdata[5:0]),
        .in_coef_value (s_axis_tdata[21:6]),
        .ring_wr_addr  (ring_wr_addr),
        .ring_rd_addr  (ring_rd_addr),
        .win_rd_addr   (win_rd_addr),
        .work_a_addr   (work_a_addr),
        .work_b_addr   (work_b_addr),
        .work_wr_addr  (work_wr_addr),
        .tw_k          (tw_k),
        .out_bin       (out_bin),
        .out_frame     (out_frame),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready),
        .m_bin         (m_bin),
        .m_frame       (m_frame),
        .m_real        (m_real),
        .m_imag        (m_imag),
        .m_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, m_imag, m_real, m_frame, m_bin};

endmodule

// File: tb/sv/windowed_stft_frame_engine_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_stft_frame_engine_checker
// Watches the sample, configuration and bin streams of the STFT frame engine,
// predicts every bin of every frame and compares each bin beat field by field.
// ----------------------------------------------------------------------------
module windowed_stft_frame_engine_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    output int          mismatches,
    output int          bins_pending
);
    import wsfe_pkg::*;

    typedef struct {
        logic [5:0]  bin;
        logic [15:0] frame;
        logic [22:0] re;
        logic [22:0] im;
        logic        last;
    } bin_t;

    localparam int QC[17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                              23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

    bin_t                bin_queue[$];
    logic signed [15:0]  ring[64];
    logic [15:0]         coefs[64];
    logic [5:0]          wr_ptr;
    int unsigned         countdown;
    logic [15:0]         frame_num;
    logic [6:0]          win_len;
    logic [12:0]         hop_len;
    longint              fre[64];
    longint              fim[64];

    function automatic longint rnd15(longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic longint cos_tw(int k);
        k = k & 31;
        return (k <= 16) ? QC[k] : -QC[32 - k];
    endfunction

    function automatic longint sin_tw(int k);
        k = k & 31;
        return (k <= 16) ? QC[16 - k] : QC[k - 16];
    endfunction

    function automatic int unsigned frame_len();
        if (win_len < 1) return 1;
        if (win_len > 64) return 64;
        return win_len;
    endfunction

    task automatic restart_stream();
        wr_ptr    = '0;
        countdown = frame_len();
        frame_num = '0;
    endtask

    // Windowing, bit-reversed reorder, the in-place butterflies and the expected bins of one frame.
    task automatic predict_frame();
        int unsigned len;
        int          r;
        int          h;
        int          a;
        int          b;
        longint      c;
        longint      s;
        longint      tr;
        longint      ti;
        longint      t;
        bin_t        e;
        len = frame_len();
        for (int i = 0; i < 64; i++) begin
            fre[i] = 0;
            fim[i] = 0;
        end
        for (int i = 0; i < len; i++) begin
            fre[i] = rnd15(longint'(ring[6'(wr_ptr - len + i)]) * longint'(coefs[i]));
        end
        for (int i = 0; i < 64; i++) begin
            r = 0;
            for (int k = 0; k < 6; k++) r |= ((i >> k) & 1) << (5 - k);
            if (r > i) begin
                t = fre[i]; fre[i] = fre[r]; fre[r] = t;
                t = fim[i]; fim[i] = fim[r]; fim[r] = t;
            end
        end
        for (int m = 2; m <= 64; m = m * 2) begin
            h = m / 2;
            for (int base = 0; base < 64; base += m) begin
                for (int j = 0; j < h; j++) begin
                    c  = cos_tw(j * (64 / m));
                    s  = sin_tw(j * (64 / m));
                    a  = base + j;
                    b  = base + j + h;
                    tr = rnd15(fre[b] * c + fim[b] * s);
                    ti = rnd15(fim[b] * c - fre[b] * s);
                    fre[b] = fre[a] - tr;
                    fim[b] = fim[a] - ti;
                    fre[a] = fre[a] + tr;
                    fim[a] = fim[a] + ti;
                end
            end
        end
        for (int i = 0; i <= 32; i++) begin
            e.bin   = 6'(i);
            e.frame = frame_num;
            e.re    = fre[i][22:0];
            e.im    = fim[i][22:0];
            e.last  = (i == 32);
            bin_queue.push_back(e);
        end
        frame_num = frame_num + 1'b1;
    endtask

    task automatic take_item(action_t act, logic [5:0] idx, logic [15:0] val,
                             logic signed [15:0] smp);
        case (act)
            ACT_LOAD_COEF: begin
                coefs[idx] = (val > COEF_ONE) ? COEF_ONE : val;
            end
            ACT_RESTART: begin
                restart_stream();
            end
            ACT_PUSH: begin
                ring[wr_ptr] = smp;
                wr_ptr       = wr_ptr + 1'b1;
                if (countdown <= 1) begin
                    countdown = (hop_len == 0) ? 1 : hop_len;
                    predict_frame();
                end else begin
                    countdown--;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_bin();
        bin_t got;
        bin_t want;
        got.bin   = m_axis_tdata[5:0];
        got.frame = m_axis_tdata[21:6];
        got.re    = m_axis_tdata[44:22];
        got.im    = m_axis_tdata[67:45];
        got.last  = m_axis_tlast;
        if (bin_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected bin beat: bin %0d frame %0d", got.bin, got.frame);
            return;
        end
        want = bin_queue.pop_front();
        if (got.bin != want.bin || got.frame != want.frame || got.re != want.re ||
            got.im != want.im || got.last != want.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("bin mismatch: expected bin %0d frame %0d re %h im %h last %b,",
                         want.bin, want.frame, want.re, want.im, want.last,
                         " got bin %0d frame %0d re %h im %h last %b",
                         got.bin, got.frame, got.re, got.im, got.last);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            win_len = WLEN_MAX;
            hop_len = HOP_RESET;
            mismatches = 0;
            bin_queue.delete();
            restart_stream();
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_bin();
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_WINDOW_LENGTH) begin
                    win_len = cfg_data[6:0];
                    restart_stream();
                end else begin
                    hop_len = cfg_data;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                take_item(action_t'(s_axis_tuser), s_axis_tdata[5:0], s_axis_tdata[21:6],
                          s_axis_tdata[37:22]);
        end
        bins_pending = bin_queue.size();
    end

endmodule

// File: tb/sv/windowed_stft_frame_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_stft_frame_engine_unit_tb
// Drives window loads, samples and restarts into the STFT frame engine across
// several window and hop settings with random idling on both streams; the
// checker predicts and compares every bin.
// ----------------------------------------------------------------------------
module windowed_stft_frame_engine_unit_tb;
    import wsfe_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [12:0] cfg_data;
    int          mismatches;
    int          bins_pending;
    int          send_idle;
    int          recv_idle;
    int          quiet_cycles;

    windowed_stft_frame_engine_unit dut (.*);

    windowed_stft_frame_engine_checker checker_i (.*);

    always begin
        aclk = 1'b1; #6;
        aclk = 1'b0; #6;
    end

    always @(negedge aclk) m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[windowed_stft_frame_engine_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_beat(action_t act, logic [5:0] idx, logic [15:0] val,
                             logic [15:0] smp);
        if ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {2'b00, smp, val, idx};
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic push_sample(logic [15:0] smp);
        send_beat(ACT_PUSH, 6'($urandom), 16'($urandom), smp);
    endtask

    task automatic drain_bins();
        while (bins_pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [12:0] value);
        drain_bins();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_run(int count);
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) drain_bins();
            if (roll < 72)      push_sample(16'($urandom));
            else if (roll < 84) send_beat(ACT_LOAD_COEF, 6'($urandom), 16'($urandom), 16'($urandom));
            else if (roll < 91) send_beat(ACT_RESTART, 6'($urandom), 16'($urandom), 16'($urandom));
            else                send_beat(ACT_NOP, 6'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_NOP;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_WINDOW_LENGTH;
        cfg_data      = '0;
        send_idle     = 13;
        recv_idle     = 54;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Fill the whole window table first so no frame reads an unloaded entry.
        send_beat(ACT_LOAD_COEF, 6'd0, 16'd0, 16'h0000);
        send_beat(ACT_LOAD_COEF, 6'd1, COEF_ONE, 16'h0000);
        send_beat(ACT_LOAD_COEF, 6'd2, 16'hFFFF, 16'h0000);
        send_beat(ACT_LOAD_COEF, 6'd3, 16'd1, 16'h0000);
        for (int i = 4; i < 64; i++)
            send_beat(ACT_LOAD_COEF, 6'(i), 16'($urandom_range(0, 32768)), 16'h0000);

        // Reset settings: one full 64-sample frame, then a hop of 32.
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        push_sample(16'hFFFF);
        push_sample(16'h0000);
        for (int i = 4; i < 96; i++) push_sample(16'($urandom));

        // Shortest window and hop: every sample makes a frame.
        write_reg(CFG_WINDOW_LENGTH, 13'd1);
        write_reg(CFG_HOP_LENGTH, 13'd1);
        push_sample(16'h7FFF);
        push_sample(16'h8000);
        send_beat(ACT_NOP, 6'd63, 16'hFFFF, 16'hFFFF);
        send_beat(ACT_RESTART, 6'd0, 16'd0, 16'h0000);
        push_sample(16'h0001);

        // A long hop: one frame, then the samples after it are skipped.
        write_reg(CFG_WINDOW_LENGTH, 13'd64);
        write_reg(CFG_HOP_LENGTH, 13'd4096);
        for (int i = 0; i < 70; i++) push_sample(16'($urandom));

        for (int mode = 0; mode < 3; mode++) begin
            send_idle = (mode == 0) ? 13 : (mode == 1) ? 54 : 0;
            recv_idle = (mode == 0) ? 54 : (mode == 1) ? 13 : 0;
            for (int p = 0; p < 3; p++) begin
                write_reg(CFG_WINDOW_LENGTH, 13'($urandom_range(1, 64)));
                write_reg(CFG_HOP_LENGTH, 13'($urandom_range(1, 40)));
                random_run(22);
            end
        end

        while (bins_pending != 0) @(negedge aclk);
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[windowed_stft_frame_engine_unit] OK");
        end else begin
            $display("[windowed_stft_frame_engine_unit] ERROR");
        end
        $finish;
    end

endmodule
